>>> rtl/core/sidx_pkg.sv
// Segment index box parser: shared types and constants.
// Used by the byte parser, queue, accumulators, top level and testbench; no dependencies.
`timescale 1ns / 1ps
package sidx_pkg;

  localparam int PHASE_W = 6;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;
  localparam int CFG_IDX_W = 1;

  // byte phases of the box
  localparam logic [PHASE_W-1:0] PH_SIZE_END    = 6'd3;
  localparam logic [PHASE_W-1:0] PH_VERSION     = 6'd8;
  localparam logic [PHASE_W-1:0] PH_TSCALE_END  = 6'd19;
  localparam logic [PHASE_W-1:0] PH_TIME_END_V0 = 6'd23;
  localparam logic [PHASE_W-1:0] PH_TIME_END_V1 = 6'd27;
  localparam logic [PHASE_W-1:0] PH_OFFS_END_V0 = 6'd27;
  localparam logic [PHASE_W-1:0] PH_OFFS_END_V1 = 6'd35;
  localparam logic [PHASE_W-1:0] PH_CNT_END_V0  = 6'd31;
  localparam logic [PHASE_W-1:0] PH_CNT_END_V1  = 6'd39;
  localparam logic [PHASE_W-1:0] PH_REF_FIRST   = 6'd40;
  localparam logic [PHASE_W-1:0] PH_RSIZE_END   = 6'd43;
  localparam logic [PHASE_W-1:0] PH_RDUR_END    = 6'd47;
  localparam logic [PHASE_W-1:0] PH_REF_LAST    = 6'd51;
  localparam logic [PHASE_W-1:0] PH_DONE        = 6'd52;

  localparam logic [31:0] SIZE_MASK = 32'h7FFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BEGIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_END   = 1'b1;

  typedef enum logic [2:0] {
    OP_SIZE,
    OP_TSCALE,
    OP_TIME,
    OP_OFFSET,
    OP_COUNT,
    OP_RSIZE,
    OP_RDUR,
    OP_EMIT
  } sidx_op_t;

  typedef struct packed {
    sidx_op_t    op;
    logic [63:0] data;
    logic [15:0] index;
    logic        last;
  } sidx_cmd_t;

endpackage

>>> rtl/core/sidx_in_if.sv
// Byte channel into the segment index box parser.
// Stands alone; valid/ready handshake.
`timescale 1ns / 1ps
interface sidx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       box_start;

  modport source (output valid, output data_byte, output box_start, input ready);
  modport sink (input valid, input data_byte, input box_start, output ready);
endinterface

>>> rtl/core/sidx_out_if.sv
// Entry channel out of the segment index box parser.
// Stands alone; valid/ready handshake.
`timescale 1ns / 1ps
interface sidx_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] entry_index;
  logic [63:0] start_ticks;
  logic [31:0] duration_ticks;
  logic [63:0] seg_offset;
  logic [30:0] seg_size;
  logic [31:0] ticks_per_second;
  logic [63:0] duration_sum;
  logic        last_entry;
  logic        box_too_long;

  modport source (
    output valid, output entry_index, output start_ticks, output duration_ticks,
    output seg_offset, output seg_size, output ticks_per_second,
    output duration_sum, output last_entry, output box_too_long, input ready
  );
  modport sink (
    input valid, input entry_index, input start_ticks, input duration_ticks,
    input seg_offset, input seg_size, input ticks_per_second,
    input duration_sum, input last_entry, input box_too_long, output ready
  );
endinterface

>>> rtl/core/sidx_front.sv
// Byte parser: tracks the byte phase, assembles fields, issues commands.
// Depends on sidx_pkg and sidx_in_if.
`timescale 1ns / 1ps
module sidx_front import sidx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sidx_in_if.sink   in_ch,
  input  logic      q_full,
  output logic      push_vld,
  output sidx_cmd_t push_cmd
);

  logic [PHASE_W-1:0] phase_r, phase_nxt, p;
  logic [PHASE_W-1:0] t_end, o_end, c_end;
  logic [63:0]        shift_r, shift_nxt;
  logic               version_r, version_nxt, ver;
  logic [15:0]        total_r, total_nxt;
  logic [15:0]        done_r, done_nxt;
  logic [31:0]        w32;
  logic [63:0]        wide;
  logic               last;
  logic               acc;
  logic               active;
  logic               push_any;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign push_vld    = acc && push_any;

  always_comb begin
    p         = in_ch.box_start ? '0 : phase_r;
    ver       = in_ch.box_start ? 1'b0 : version_r;
    shift_nxt = {(in_ch.box_start ? 56'd0 : shift_r[55:0]), in_ch.data_byte};
    w32       = shift_nxt[31:0];
    wide      = ver ? shift_nxt : {32'd0, w32};
    t_end     = ver ? PH_TIME_END_V1 : PH_TIME_END_V0;
    o_end     = ver ? PH_OFFS_END_V1 : PH_OFFS_END_V0;
    c_end     = ver ? PH_CNT_END_V1 : PH_CNT_END_V0;
    last      = ({1'b0, done_r} + 17'd1) >= {1'b0, total_r};
    active    = (p != PH_DONE);

    phase_nxt   = p + PHASE_W'(1);
    version_nxt = ver;
    total_nxt   = total_r;
    done_nxt    = done_r;
    push_any    = 1'b0;
    push_cmd    = '{op: OP_SIZE, data: wide, index: done_r, last: last};

    if (active) begin
      if (p < PH_REF_FIRST) begin
        priority if (p == PH_SIZE_END) begin
          push_any = 1'b1;
        end else if (p == PH_VERSION) begin
          version_nxt = (in_ch.data_byte != 8'd0);
        end else if (p == PH_TSCALE_END) begin
          push_any    = 1'b1;
          push_cmd.op = OP_TSCALE;
        end else if (p == t_end) begin
          push_any    = 1'b1;
          push_cmd.op = OP_TIME;
        end else if (p == o_end) begin
          push_any    = 1'b1;
          push_cmd.op = OP_OFFSET;
        end else if (p == c_end) begin
          push_any    = 1'b1;
          push_cmd.op = OP_COUNT;
          total_nxt   = w32[15:0];
          done_nxt    = '0;
          phase_nxt   = (w32[15:0] == 16'd0) ? PH_DONE : PH_REF_FIRST;
        end else begin
          push_any = 1'b0;
        end
      end else begin
        priority if (p == PH_RSIZE_END) begin
          push_any    = 1'b1;
          push_cmd.op = OP_RSIZE;
        end else if (p == PH_RDUR_END) begin
          push_any    = 1'b1;
          push_cmd.op = OP_RDUR;
        end else if (p == PH_REF_LAST) begin
          push_any    = 1'b1;
          push_cmd.op = OP_EMIT;
          done_nxt    = done_r + 16'd1;
          phase_nxt   = last ? PH_DONE : PH_REF_FIRST;
        end else begin
          push_any = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      shift_r   <= '0;
      version_r <= 1'b0;
      total_r   <= '0;
      done_r    <= '0;
    end else if (acc && active) begin
      phase_r   <= phase_nxt;
      shift_r   <= shift_nxt;
      version_r <= version_nxt;
      total_r   <= total_nxt;
      done_r    <= done_nxt;
    end
  end

endmodule

>>> rtl/core/sidx_queue.sv
// Short command queue between the byte parser and the accumulators.
// Depends on sidx_pkg.
`timescale 1ns / 1ps
module sidx_queue import sidx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_vld,
  input  sidx_cmd_t push_cmd,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output sidx_cmd_t head
);

  sidx_cmd_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r, rptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_vld && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push_vld) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_vld) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push_vld) begin
        wptr_r <= wptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + Q_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/sidx_back.sv
// Accumulators, configuration registers and the entry output register.
// Depends on sidx_pkg and sidx_out_if.
`timescale 1ns / 1ps
module sidx_back import sidx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic                 q_empty,
  input  sidx_cmd_t            head,
  output logic                 pop,
  sidx_out_if.source           out_ch
);

  logic [31:0] begin_r, end_r;
  logic        overrun_r;
  logic [31:0] tscale_r;
  logic [63:0] time_r, offset_r, sum_r, sum_nxt;
  logic [30:0] psize_r;
  logic [31:0] pdur_r;
  logic        ovr_nxt;

  logic        out_valid_r;
  logic [15:0] o_index_r;
  logic [63:0] o_start_r, o_offset_r, o_sum_r;
  logic [31:0] o_dur_r, o_tscale_r;
  logic [30:0] o_size_r;
  logic        o_last_r, o_ovr_r;

  assign pop = !q_empty && (head.op != OP_EMIT || !out_valid_r || out_ch.ready);
  assign sum_nxt = sum_r + {32'd0, pdur_r};
  assign ovr_nxt = ({1'b0, begin_r} + {1'b0, head.data[31:0]}) > ({1'b0, end_r} + 33'd1);

  assign out_ch.valid            = out_valid_r;
  assign out_ch.entry_index      = o_index_r;
  assign out_ch.start_ticks      = o_start_r;
  assign out_ch.duration_ticks   = o_dur_r;
  assign out_ch.seg_offset       = o_offset_r;
  assign out_ch.seg_size         = o_size_r;
  assign out_ch.ticks_per_second = o_tscale_r;
  assign out_ch.duration_sum     = o_sum_r;
  assign out_ch.last_entry       = o_last_r;
  assign out_ch.box_too_long     = o_ovr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      begin_r     <= '0;
      end_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INDEX_BEGIN: begin_r <= cfg_wdata;
          CFG_INDEX_END:   end_r   <= cfg_wdata;
          default:         end_r   <= end_r;
        endcase
      end
      if (pop && head.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // accumulator state is rewritten by every box header before its first entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overrun_r <= 1'b0;
      tscale_r  <= '0;
      time_r    <= '0;
      offset_r  <= '0;
      sum_r     <= '0;
      psize_r   <= '0;
      pdur_r    <= '0;
    end else if (pop) begin
      unique case (head.op)
        OP_SIZE:   overrun_r <= ovr_nxt;
        OP_TSCALE: tscale_r  <= head.data[31:0];
        OP_TIME:   time_r    <= head.data;
        OP_OFFSET: offset_r  <= {32'd0, end_r} + 64'd1 + head.data;
        OP_COUNT:  sum_r     <= '0;
        OP_RSIZE:  psize_r   <= head.data[30:0];
        OP_RDUR:   pdur_r    <= head.data[31:0];
        OP_EMIT: begin
          sum_r    <= sum_nxt;
          time_r   <= time_r + {32'd0, pdur_r};
          offset_r <= offset_r + {33'd0, psize_r};
        end
        default: sum_r <= sum_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.op == OP_EMIT) begin
      o_index_r  <= head.index;
      o_start_r  <= time_r;
      o_dur_r    <= pdur_r;
      o_offset_r <= offset_r;
      o_size_r   <= psize_r;
      o_tscale_r <= tscale_r;
      o_sum_r    <= sum_nxt;
      o_last_r   <= head.last;
      o_ovr_r    <= overrun_r;
    end
  end

endmodule

>>> rtl/core/segment_index_box_parser_unit.sv
// Segment index box parser, top level.
// Depends on sidx_pkg, sidx_in_if, sidx_out_if, sidx_front, sidx_queue, sidx_back.
// Takes one byte of the box per cycle while the queue has room. The byte parser
// issues a command for each completed field into a four-word queue; the
// accumulator side drains one command per cycle unless an entry command meets a
// held output, and loads the entry output register from the last command of each
// 12-byte reference. Bytes are refused only when the queue is full, which happens
// only while a finished entry waits to be taken. No clearing pass after reset.
`timescale 1ns / 1ps
module segment_index_box_parser_unit import sidx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  sidx_in_if.sink              in_ch,
  sidx_out_if.source           out_ch
);

  logic      push_vld;
  sidx_cmd_t push_cmd;
  logic      q_full;
  logic      q_empty;
  logic      pop;
  sidx_cmd_t head;

  sidx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push_vld (push_vld),
    .push_cmd (push_cmd)
  );

  sidx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_vld (push_vld),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  sidx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

>>> rtl/core/sidx_checker.sv
// Port-level checks for the segment index box parser, bound to the top level.
// Depends on sidx_in_if and sidx_out_if.
`timescale 1ns / 1ps
module sidx_checker (
  input logic        clk,
  input logic        rst_n,
  sidx_in_if.sink    in_ch,
  sidx_out_if.source out_ch
);

  // a held word keeps its entry index and duration sum
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=>
      out_ch.valid && $stable(out_ch.entry_index) && $stable(out_ch.duration_sum))
    else $error("output word changed while stalled");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  a_rst_rdy: assert property (@(posedge clk) !rst_n |=> in_ch.ready)
    else $error("input not ready after reset");

  // first entry of a box carries its own duration as the running sum
  a_first_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.entry_index == 16'd0 |->
      out_ch.duration_sum == {32'd0, out_ch.duration_ticks})
    else $error("duration sum of first entry wrong");

endmodule

bind segment_index_box_parser_unit sidx_checker u_sidx_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

>>> tb/sv/sidx_entry_ledger_pkg.sv
// Expected-entry ledger for the segment index box parser testbench.
// Depends on sidx_pkg; mirrors the parser state byte by byte and checks each entry.
`timescale 1ns / 1ps
package sidx_entry_ledger_pkg;
  import sidx_pkg::*;

  typedef struct packed {
    logic [15:0] entry_index;
    logic [63:0] start_ticks;
    logic [31:0] duration_ticks;
    logic [63:0] seg_offset;
    logic [30:0] seg_size;
    logic [31:0] ticks_per_second;
    logic [63:0] duration_sum;
    logic        last_entry;
    logic        box_too_long;
  } sidx_entry_t;

  class sidx_entry_ledger;
    logic [31:0]        win_begin;
    logic [31:0]        win_end;
    logic [PHASE_W-1:0] phase;
    logic [63:0]        shift;
    logic               version;
    logic [31:0]        tscale;
    logic [63:0]        time_acc;
    logic [63:0]        offset_acc;
    logic [15:0]        refs_total;
    logic [15:0]        refs_done;
    logic [30:0]        pend_size;
    logic [31:0]        pend_dur;
    logic [63:0]        dur_sum;
    logic               overrun;
    sidx_entry_t        pending_entries[$];
    int                 errors;
    int                 bytes_parsed;
    int                 entries_checked;

    function new();
      win_begin = '0;
      win_end = '0;
      errors = 0;
      bytes_parsed = 0;
      entries_checked = 0;
      clear_box();
    endfunction

    function void clear_box();
      phase = '0;
      shift = '0;
      version = 1'b0;
      tscale = '0;
      time_acc = '0;
      offset_acc = '0;
      refs_total = '0;
      refs_done = '0;
      pend_size = '0;
      pend_dur = '0;
      dur_sum = '0;
      overrun = 1'b0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        CFG_INDEX_BEGIN: win_begin = value;
        CFG_INDEX_END:   win_end = value;
        default: ;
      endcase
    endfunction

    // one accepted byte of the box
    function void take_byte(logic [7:0] value, logic start);
      logic [PHASE_W-1:0] p;
      logic [PHASE_W-1:0] t_end;
      logic [PHASE_W-1:0] o_end;
      logic [PHASE_W-1:0] c_end;
      logic [31:0]        w;
      logic [31:0]        masked;
      logic               last;
      sidx_entry_t        e;
      if (start) clear_box();
      p = phase;
      if (p >= PH_DONE) return;
      bytes_parsed++;
      shift = {shift[55:0], value};
      w = shift[31:0];
      phase = p + 1'b1;
      if (p < PH_REF_FIRST) begin
        t_end = version ? PH_TIME_END_V1 : PH_TIME_END_V0;
        o_end = version ? PH_OFFS_END_V1 : PH_OFFS_END_V0;
        c_end = version ? PH_CNT_END_V1 : PH_CNT_END_V0;
        if (p == PH_SIZE_END) begin
          overrun = ({32'd0, win_begin} + {32'd0, w}) > ({32'd0, win_end} + 64'd1);
        end else if (p == PH_VERSION) begin
          version = (value != 8'd0);
        end else if (p == PH_TSCALE_END) begin
          tscale = w;
        end else if (p == t_end) begin
          time_acc = version ? shift : {32'd0, w};
        end else if (p == o_end) begin
          offset_acc = {32'd0, win_end} + 64'd1 + (version ? shift : {32'd0, w});
        end else if (p == c_end) begin
          refs_total = w[15:0];
          refs_done = '0;
          dur_sum = '0;
          phase = (refs_total == 16'd0) ? PH_DONE : PH_REF_FIRST;
        end
        return;
      end
      if (p == PH_RSIZE_END) begin
        masked = w & SIZE_MASK;
        pend_size = masked[30:0];
      end else if (p == PH_RDUR_END) begin
        pend_dur = w;
      end else if (p == PH_REF_LAST) begin
        last = ({1'b0, refs_done} + 17'd1) >= {1'b0, refs_total};
        dur_sum = dur_sum + {32'd0, pend_dur};
        e.entry_index = refs_done;
        e.start_ticks = time_acc;
        e.duration_ticks = pend_dur;
        e.seg_offset = offset_acc;
        e.seg_size = pend_size;
        e.ticks_per_second = tscale;
        e.duration_sum = dur_sum;
        e.last_entry = last;
        e.box_too_long = overrun;
        pending_entries.insert(pending_entries.size(), e);
        time_acc = time_acc + {32'd0, pend_dur};
        offset_acc = offset_acc + {33'd0, pend_size};
        refs_done = refs_done + 16'd1;
        phase = last ? PH_DONE : PH_REF_FIRST;
      end
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_entry(sidx_entry_t got);
      sidx_entry_t want;
      if (pending_entries.size() == 0) begin
        $error("entry %0d arrived with none expected", got.entry_index);
        errors++;
        return;
      end
      want = pending_entries.pop_front();
      entries_checked++;
      compare("entry_index", 64'(want.entry_index), 64'(got.entry_index));
      compare("start_ticks", want.start_ticks, got.start_ticks);
      compare("duration_ticks", 64'(want.duration_ticks), 64'(got.duration_ticks));
      compare("seg_offset", want.seg_offset, got.seg_offset);
      compare("seg_size", 64'(want.seg_size), 64'(got.seg_size));
      compare("ticks_per_second", 64'(want.ticks_per_second), 64'(got.ticks_per_second));
      compare("duration_sum", want.duration_sum, got.duration_sum);
      compare("last_entry", 64'(want.last_entry), 64'(got.last_entry));
      compare("box_too_long", 64'(want.box_too_long), 64'(got.box_too_long));
    endfunction
  endclass

endpackage

>>> tb/sv/segment_index_box_parser_unit_test.sv
// Top-level testbench for segment_index_box_parser_unit: directed and random boxes.
// Depends on sidx_pkg, sidx_in_if, sidx_out_if and sidx_entry_ledger_pkg.
`timescale 1ns / 1ps
module segment_index_box_parser_unit_test;
  import sidx_pkg::*;
  import sidx_entry_ledger_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_WORDS = 160;

  typedef enum {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_t;
  typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZERO} ref_fill_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;

  sidx_in_if  in_ch();
  sidx_out_if out_ch();

  segment_index_box_parser_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  sidx_entry_ledger ledger;
  flow_t            flow = FLOW_FREE;
  logic [7:0]       box_bytes[$];
  sidx_entry_t      seen_entry;
  int               quiet_cycles = 0;
  int               box_count = 0;

  always #2 clk = ~clk;

  function automatic int src_idle_pct();
    case (flow)
      FLOW_SRC_IDLE: return 71;
      FLOW_BOTH:     return 28;
      default:       return 0;
    endcase
  endfunction

  function automatic int snk_stall_pct();
    case (flow)
      FLOW_SNK_STALL: return 71;
      FLOW_BOTH:      return 28;
      default:        return 0;
    endcase
  endfunction

  function automatic logic [31:0] rand_word32();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [63:0] rand_word64();
    case ($urandom_range(7))
      0:       return 64'd0;
      1:       return ~64'd0 - 64'($urandom_range(255));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic void push_field(logic [63:0] value, int n);
    for (int i = n - 1; i >= 0; i--) box_bytes.insert(box_bytes.size(), value[i*8 +: 8]);
  endfunction

  function automatic int box_length(logic [7:0] ver, int nrefs);
    return ((ver != 8'd0) ? 40 : 32) + 12 * nrefs;
  endfunction

  function automatic void build_box(logic [7:0] ver, logic [31:0] size, logic [31:0] tscale,
                                    logic [63:0] t0, logic [63:0] off0, logic [15:0] count,
                                    int nrefs, ref_fill_t fill);
    int fw;
    box_bytes.delete();
    fw = (ver != 8'd0) ? 8 : 4;
    push_field(64'(size), 4);
    push_field(64'h7369_6478, 4);
    push_field(64'(ver), 1);
    push_field(64'($urandom()), 3);
    push_field(64'($urandom()), 4);
    push_field(64'(tscale), 4);
    push_field(t0, fw);
    push_field(off0, fw);
    push_field(64'($urandom()), 2);
    push_field(64'(count), 2);
    for (int r = 0; r < nrefs; r++) begin
      case (fill)
        FILL_ONES: begin
          push_field(64'hFFFF_FFFF, 4);
          push_field(64'hFFFF_FFFF, 4);
        end
        FILL_ZERO: begin
          push_field(64'd0, 4);
          push_field(64'd0, 4);
        end
        default: begin
          push_field(64'(rand_word32()), 4);
          push_field(64'(rand_word32()), 4);
        end
      endcase
      push_field(64'($urandom()), 4);
    end
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic start);
    while ($urandom_range(99) < src_idle_pct()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= value;
    in_ch.box_start <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ledger.take_byte(value, start);
  endtask

  task automatic send_box(input int n, input logic mark);
    for (int i = 0; i < n; i++) send_byte(box_bytes[i], mark && (i == 0));
    box_count++;
  endtask

  task automatic send_noise(input int n, input logic allow_start);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom_range(255)), allow_start && ($urandom_range(7) == 0));
  endtask

  // let the queue drain before touching the window registers
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_window(input logic [31:0] first, input logic [31:0] last);
    cfg_we <= 1'b1;
    cfg_index <= CFG_INDEX_BEGIN;
    cfg_wdata <= first;
    @(posedge clk);
    ledger.write_register(CFG_INDEX_BEGIN, first);
    cfg_index <= CFG_INDEX_END;
    cfg_wdata <= last;
    @(posedge clk);
    ledger.write_register(CFG_INDEX_END, last);
    cfg_we <= 1'b0;
  endtask

  task automatic random_box();
    logic [7:0]  ver;
    logic [15:0] count;
    logic [31:0] size;
    int          nrefs;
    int          roll;
    case ($urandom_range(3))
      0, 2:    ver = 8'h00;
      1:       ver = 8'h01;
      default: ver = 8'($urandom_range(255));
    endcase
    nrefs = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
    count = 16'(nrefs);
    if ($urandom_range(9) == 0) count = 16'($urandom_range(nrefs + 1, 65535));
    size = $urandom_range(1) ? 32'(box_length(ver, nrefs)) : rand_word32();
    build_box(ver, size, rand_word32(), rand_word64(), rand_word64(), count, nrefs,
              FILL_RANDOM);
    roll = $urandom_range(99);
    if (roll < 70) begin
      send_box(box_bytes.size(), 1'b1);
      if ($urandom_range(4) == 0) send_noise($urandom_range(1, 6), 1'b0);
    end else if (roll < 85) begin
      send_box($urandom_range(1, box_bytes.size() - 1), 1'b1);
    end else begin
      send_noise($urandom_range(1, 20), 1'b1);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_entry.entry_index = out_ch.entry_index;
      seen_entry.start_ticks = out_ch.start_ticks;
      seen_entry.duration_ticks = out_ch.duration_ticks;
      seen_entry.seg_offset = out_ch.seg_offset;
      seen_entry.seg_size = out_ch.seg_size;
      seen_entry.ticks_per_second = out_ch.ticks_per_second;
      seen_entry.duration_sum = out_ch.duration_sum;
      seen_entry.last_entry = out_ch.last_entry;
      seen_entry.box_too_long = out_ch.box_too_long;
      ledger.check_entry(seen_entry);
    end
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct());
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int target;
    ledger = new();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_INDEX_BEGIN;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.box_start <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // first box straight after reset, no start marker; zero size at zero is not flagged
    build_box(8'h00, 32'd0, 32'd90000, 64'd0, 64'd0, 16'd2, 2, FILL_RANDOM);
    send_box(box_bytes.size(), 1'b0);
    send_noise(3, 1'b0);
    settle();

    program_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    build_box(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0, ~64'd0,
              16'd3, 3, FILL_ONES);
    send_box(box_bytes.size(), 1'b1);
    build_box(8'h01, 32'd40, 32'd0, 64'd0, 64'd0, 16'd0, 0, FILL_RANDOM);
    send_box(box_bytes.size(), 1'b1);
    send_noise(2, 1'b0);
    build_box(8'h00, 32'd56, 32'd1, 64'd0, 64'd0, 16'hFFFF, 2, FILL_ZERO);
    send_box(box_bytes.size(), 1'b1);
    build_box(8'h01, 32'd52, 32'd1000, 64'd5, 64'd7, 16'd1, 1, FILL_RANDOM);
    send_box(20, 1'b1);
    build_box(8'h00, 32'd44, 32'd48000, 64'd100, 64'd200, 16'd1, 1, FILL_RANDOM);
    send_box(box_bytes.size(), 1'b1);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: program_window(32'd0, 32'hFFFF_FFFF);
        1: program_window(32'hFFFF_FFFF, 32'd0);
        2: begin
          target = $urandom();
          program_window(target, target + $urandom_range(0, 120));
        end
        default: program_window($urandom(), $urandom());
      endcase
      flow = flow_t'(ph);
      target = ledger.bytes_parsed + PHASE_WORDS;
      while (ledger.bytes_parsed < target) random_box();
      settle();
    end

    $display("%0d box words parsed across %0d boxes, %0d entries checked", ledger.bytes_parsed,
             box_count, ledger.entries_checked);
    $display("window extremes and all four handshake patterns exercised");
    if (ledger.pending_entries.size() != 0) begin
      $error("%0d expected entries never arrived", ledger.pending_entries.size());
      ledger.errors++;
    end
    if (ledger.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/sidx_pkg.sv
rtl/core/sidx_in_if.sv
rtl/core/sidx_out_if.sv
rtl/core/sidx_front.sv
rtl/core/sidx_queue.sv
rtl/core/sidx_back.sv
rtl/core/segment_index_box_parser_unit.sv
rtl/core/sidx_checker.sv
tb/sv/sidx_entry_ledger_pkg.sv
tb/sv/segment_index_box_parser_unit_test.sv
